// ===== rtl/core/sfsc_pkg.sv =====
package sfsc_pkg;

  // Header signature bytes
  localparam logic [7:0] SigB    = 8'h42;
  localparam logic [7:0] SigCmd  = 8'h10;
  localparam logic [7:0] SigCall = 8'h16;
  localparam logic [7:0] SigStat = 8'h00;

  // Frame length limits
  localparam logic [7:0] MinFrameLen   = 8'd8;
  localparam logic [7:0] MaxLenReset   = 8'd96;
  localparam logic [3:0] HeaderBytes   = 4'd8;

  // Command from the front part to the checksum back part
  typedef struct packed {
    logic            start;  // header lock, hdr is valid
    logic            last;   // final beat of the frame
    logic            odd;    // data byte sits at an odd frame position
    logic [7:0]      data;   // data byte
    logic [7:0][7:0] hdr;    // header window, index 0 is the oldest byte
  } cmd_t;

  // Completed frame result
  typedef struct packed {
    logic        status;
    logic [7:0]  length;
    logic [7:0]  address;
    logic [15:0] checksum;
  } res_t;

  // Ones-complement add with end-around carry
  function automatic logic [15:0] add_word(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/core/signature_frame_sync_checksum.sv =====
// Frame synchronizer with Internet-style checksum check. Bytes from a serial
// line enter through push/full. While hunting, the last eight bytes are
// compared against the header signature ('B', 0x10, 0x16, 0x00 at bytes 2, 3,
// 6, 7) and a length byte between 8 and max_frame_length; once locked, the
// frame is counted to its length and summed as little-endian 16-bit words
// with end-around carry, with the received checksum bytes taken as zero.
// Each completed frame yields one result on empty/pop: status 0 when the
// complemented sum equals bytes 4 (low) and 5 (high). The block takes one
// byte per cycle while full is low, through the combinational window compare
// in the front part and sum update in the back part; full rises when the
// command queue fills, as when the result queue is full and not popped. A
// result enters the result queue when the back part takes the final beat of
// its frame. A two-beat command queue parts the front from the back and a
// two-beat result queue holds finished frames. Write max_frame_length only
// while idle; it is sampled when a header locks and resets to 96.
module signature_frame_sync_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        frame_status_o,
  output logic [7:0]  frame_length_o,
  output logic [7:0]  device_address_o,
  output logic [15:0] computed_checksum_o
);

  logic [7:0]     max_len_q;
  logic           cmd_valid;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;
  sfsc_pkg::cmd_t cmd_wr;
  sfsc_pkg::cmd_t cmd_rd;
  sfsc_pkg::res_t res;

  // Hold the frame length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sfsc_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  sfsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len_q),
    .cmd_valid_o (cmd_valid),
    .cmd_full_i  (cmd_full),
    .cmd_o       (cmd_wr)
  );

  sfsc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .wdata_i (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_rd)
  );

  sfsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign frame_status_o      = res.status;
  assign frame_length_o      = res.length;
  assign device_address_o    = res.address;
  assign computed_checksum_o = res.checksum;

endmodule

// ===== rtl/core/sfsc_front.sv =====
module sfsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         max_len_i,
  output logic               cmd_valid_o,
  input  logic               cmd_full_i,
  output sfsc_pkg::cmd_t     cmd_o
);

  logic            locked_q, locked_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      len_q, len_d;
  logic [3:0]      fill_q, fill_d;
  logic [7:0][7:0] win_q, win_d;
  logic            accept;
  logic            hdr_match;
  logic [7:0]      count_inc;

  assign full      = cmd_full_i;
  assign accept    = push && !cmd_full_i;
  assign count_inc = count_q + 8'd1;

  // Shift the hunting window by one byte
  always_comb begin
    win_d    = {rx_byte_i, win_q[7:1]};
    hdr_match = (win_d[2] == sfsc_pkg::SigB) && (win_d[3] == sfsc_pkg::SigCmd) &&
                (win_d[6] == sfsc_pkg::SigCall) && (win_d[7] == sfsc_pkg::SigStat) &&
                (win_d[0] >= sfsc_pkg::MinFrameLen) && (win_d[0] <= max_len_i);
  end

  // Classify the byte and build the command
  always_comb begin
    locked_d    = locked_q;
    count_d     = count_q;
    len_d       = len_q;
    fill_d      = fill_q;
    cmd_valid_o = 1'b0;
    cmd_o.start = 1'b0;
    cmd_o.last  = 1'b0;
    cmd_o.odd   = count_q[0];
    cmd_o.data  = rx_byte_i;
    cmd_o.hdr   = win_d;
    if (accept) begin
      if (locked_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.last  = (count_inc == len_q);
        count_d     = count_inc;
        if (count_inc == len_q) begin
          locked_d = 1'b0;
          fill_d   = 4'd0;
        end
      end else begin
        if (fill_q < sfsc_pkg::HeaderBytes) begin
          fill_d = fill_q + 4'd1;
        end
        if ((fill_d == sfsc_pkg::HeaderBytes) && hdr_match) begin
          cmd_valid_o = 1'b1;
          cmd_o.start = 1'b1;
          cmd_o.last  = (win_d[0] == sfsc_pkg::MinFrameLen);
          len_d       = win_d[0];
          count_d     = sfsc_pkg::MinFrameLen;
          if (win_d[0] == sfsc_pkg::MinFrameLen) begin
            fill_d = 4'd0;
          end else begin
            locked_d = 1'b1;
          end
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      count_q  <= 8'd0;
      len_q    <= 8'd0;
      fill_q   <= 4'd0;
    end else begin
      locked_q <= locked_d;
      count_q  <= count_d;
      len_q    <= len_d;
      fill_q   <= fill_d;
    end
  end

  // Advance the window on each hunting beat
  always_ff @(posedge clk_i) begin
    if (accept && !locked_q) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== rtl/core/sfsc_cmd_fifo.sv =====
module sfsc_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfsc_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sfsc_pkg::cmd_t rdata_o
);

  sfsc_pkg::cmd_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/sfsc_back.sv =====
module sfsc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  sfsc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output sfsc_pkg::res_t res_o
);

  logic [15:0]    sum_q, sum_d;
  logic [7:0]     pend_q, pend_d;
  logic [7:0]     len_q, len_d;
  logic [7:0]     addr_q, addr_d;
  logic [15:0]    rxck_q, rxck_d;
  logic [15:0]    word;
  logic [15:0]    cks;
  sfsc_pkg::res_t res_d;

  sfsc_pkg::res_t res_mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           res_full, res_push, res_pop;

  assign res_full  = (cnt_q == 2'd2);
  assign cmd_pop_o = !cmd_empty_i && !res_full;
  assign res_push  = cmd_pop_o && cmd_i.last;
  assign res_pop   = pop && !empty;
  assign empty     = (cnt_q == 2'd0);
  assign res_o     = res_mem_q[rptr_q];

  // Fold the beat into the running sum
  always_comb begin
    sum_d  = sum_q;
    pend_d = pend_q;
    len_d  = len_q;
    addr_d = addr_q;
    rxck_d = rxck_q;
    word   = cmd_i.odd ? {cmd_i.data, pend_q} : {8'd0, cmd_i.data};
    if (cmd_i.start) begin
      len_d  = cmd_i.hdr[0];
      addr_d = cmd_i.hdr[1];
      rxck_d = {cmd_i.hdr[5], cmd_i.hdr[4]};
      pend_d = 8'd0;
      sum_d  = sfsc_pkg::add_word(
                 sfsc_pkg::add_word(
                   sfsc_pkg::add_word(16'd0, {cmd_i.hdr[1], cmd_i.hdr[0]}),
                   {cmd_i.hdr[3], cmd_i.hdr[2]}),
                 {cmd_i.hdr[7], cmd_i.hdr[6]});
    end else begin
      if (!cmd_i.odd) begin
        pend_d = cmd_i.data;
      end
      if (cmd_i.odd || cmd_i.last) begin
        sum_d = sfsc_pkg::add_word(sum_q, word);
      end
    end
    cks            = ~sum_d;
    res_d.status   = (cks != rxck_d);
    res_d.length   = len_d;
    res_d.address  = addr_d;
    res_d.checksum = cks;
  end

  // Result queue occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (res_push && !res_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (res_pop && !res_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (res_push) begin
        wptr_q <= !wptr_q;
      end
      if (res_pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Hold frame state and store results
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      sum_q  <= sum_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      addr_q <= addr_d;
      rxck_q <= rxck_d;
    end
    if (res_push) begin
      res_mem_q[wptr_q] <= res_d;
    end
  end

endmodule
